// ===== design/pulse_charge_template_averager_macros.svh =====
// ----------------------------------------------------------------------------
// pulse charge template averager assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PULSE_CHARGE_TEMPLATE_AVERAGER_MACROS_SVH
`define PULSE_CHARGE_TEMPLATE_AVERAGER_MACROS_SVH

// assertion that is off while reset is asserted
`define PCTA_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pcta assertion failed");

// assertion that also holds through reset
`define PCTA_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pcta assertion failed");

`endif

// ===== design/pcta_pkg.sv =====
// ----------------------------------------------------------------------------
// pcta_pkg
// widths, constants and codes of the pulse charge template averager
// ----------------------------------------------------------------------------
package pcta_pkg;

    localparam int WAVE_LEN     = 1024;
    localparam int TEMPLATE_LEN = 40;
    localparam int SAMPLE_BITS  = 14;

    localparam int WAVE_AW = $clog2(WAVE_LEN);
    localparam int CNT_W   = $clog2(WAVE_LEN + 1);
    localparam int TPL_AW  = $clog2(TEMPLATE_LEN);
    localparam int WS_W    = WAVE_AW + 3;

    localparam int TPL_GAIN = 500;
    localparam int GAIN_W   = 9;
    localparam int FRAC_SH  = 16;
    localparam int Q8_SH    = 8;

    localparam int SUM_W  = SAMPLE_BITS + WAVE_AW + 1;
    localparam int SQ8_W  = SAMPLE_BITS + Q8_SH;
    localparam int BASE_W = SQ8_W + 1;
    localparam int D_W    = BASE_W + 1;
    localparam int CHG_W  = D_W + TPL_AW + 1;

    localparam int CHARGE_W = 29;
    localparam int AREA_W   = 28;
    localparam int WANT_W   = 16;
    localparam int SLEN_W   = 11;
    localparam int OFS_W    = 10;
    localparam int TVAL_W   = 32;
    localparam int STATUS_W = 2;

    localparam int DIV_NW = D_W + GAIN_W + FRAC_SH;
    localparam int DIV_DW = CHARGE_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = AREA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_OFS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TPL_WANTED = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_BASE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_PAST_END = 2'd2;

    localparam logic KIND_SUMMARY  = 1'b0;
    localparam logic KIND_TEMPLATE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

endpackage

// ===== design/pcta_ram.sv =====
// ----------------------------------------------------------------------------
// pcta_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module pcta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pcta_div.sv =====
// ----------------------------------------------------------------------------
// pcta_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcta_div import pcta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo
);

    localparam int STEP_W = $clog2(DIV_NW + 1);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_quo;

    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_step <= STEP_W'(DIV_NW);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rem  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                r_quo  <= {r_quo[DIV_NW-2:0], ge};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/pulse_charge_template_averager.sv =====
// ----------------------------------------------------------------------------
// pulse_charge_template_averager
// pulse charge integration and normalised template averaging
// ----------------------------------------------------------------------------
// A sample that is not the last of its waveform is taken while busy stays
// low. The last sample starts the analysis, during which busy is high: a
// search over min(search_len, length) stored samples, a sum over the
// baseline region, a baseline divide, a pass over the 40-sample window, and
// checks. A selected pulse adds a template update in which every template
// entry goes through the shared bit-serial divider and a read-modify-write
// of the accumulator memory; emitting the averaged template likewise sends
// every entry through the divider. The wave memory's single port sets the
// scan loops at one sample per cycle. Results come on o_strobe for one cycle
// each and cannot be held off; the summary comes first, then template words.
// ----------------------------------------------------------------------------
module pulse_charge_template_averager import pcta_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                       i_last_sample,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output logic                       o_strobe,
    output logic                       o_kind,
    output logic signed [CHARGE_W-1:0] o_charge,
    output logic                       o_selected,
    output logic [WAVE_AW-1:0]         o_peak_index,
    output logic [STATUS_W-1:0]        o_status,
    output logic [TPL_AW-1:0]          o_template_index,
    output logic signed [TVAL_W-1:0]   o_template_value,
    output logic                       o_last_result
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_BSUM   = 4'd3;
    localparam logic [3:0] S_BDIV   = 4'd4;
    localparam logic [3:0] S_CHG    = 4'd5;
    localparam logic [3:0] S_CLMP   = 4'd6;
    localparam logic [3:0] S_SELCK  = 4'd7;
    localparam logic [3:0] S_TRD    = 4'd8;
    localparam logic [3:0] S_TLD    = 4'd9;
    localparam logic [3:0] S_TDIV   = 4'd10;
    localparam logic [3:0] S_TDONE  = 4'd11;
    localparam logic [3:0] S_SUMM   = 4'd12;
    localparam logic [3:0] S_ERD    = 4'd13;
    localparam logic [3:0] S_ELD    = 4'd14;
    localparam logic [3:0] S_EDIV   = 4'd15;

    localparam int AS_W = DIV_NW + 2;

    logic [3:0] r_state;

    logic [SLEN_W-1:0] r_search_len;
    logic [OFS_W-1:0]  r_lead;
    logic [OFS_W-1:0]  r_gap;
    logic [AREA_W-1:0] r_area_lo;
    logic [AREA_W-1:0] r_area_hi;
    logic [WANT_W-1:0] r_wanted;

    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_end;
    logic               r_pend;
    logic [WAVE_AW-1:0] r_pidx;
    logic [WAVE_AW-1:0] r_peak;
    t_sample            r_minv;
    logic [WAVE_AW-1:0] r_ws;
    logic [WAVE_AW-1:0] r_bl;

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [BASE_W-1:0]   r_base;
    logic signed [CHG_W-1:0]    r_chg;
    logic signed [CHARGE_W-1:0] r_charge;
    logic [CHARGE_W-1:0]        r_abs;
    logic                       r_sel;
    logic [STATUS_W-1:0]        r_status;
    logic [TPL_AW-1:0]          r_j;
    logic                       r_dneg;
    logic signed [TVAL_W-1:0]   r_accv;
    logic [WANT_W-1:0]          r_selcnt;
    logic [TEMPLATE_LEN-1:0]    r_acc_vld;

    logic                       r_o_strobe;
    logic                       r_o_kind;
    logic signed [CHARGE_W-1:0] r_o_charge;
    logic                       r_o_selected;
    logic [WAVE_AW-1:0]         r_o_peak;
    logic [STATUS_W-1:0]        r_o_status;
    logic [TPL_AW-1:0]          r_o_tidx;
    logic signed [TVAL_W-1:0]   r_o_tval;
    logic                       r_o_last;

    logic                   wave_we;
    logic [WAVE_AW-1:0]     wave_addr;
    logic [SAMPLE_BITS-1:0] wave_rdata;
    t_sample                wave_rd;
    logic                   acc_we;
    logic [TVAL_W-1:0]      acc_wdata;
    logic [TVAL_W-1:0]      acc_rdata;

    logic                 scan_state;
    logic                 scan_issue;
    logic                 scan_done;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     slen_ext;
    logic [CNT_W-1:0]     lim;
    logic signed [WS_W-1:0] ws_c;
    logic signed [WS_W-1:0] bl_c;
    logic                 past_end;

    logic signed [SQ8_W-1:0]     s_q8;
    logic signed [D_W-1:0]       d_cur;
    logic [D_W-1:0]              d_mag;
    logic [D_W+GAIN_W-1:0]       prod;
    logic [SUM_W-1:0]            sum_mag;
    logic signed [TVAL_W-1:0]    acc_cur;
    logic [TVAL_W-1:0]           acc_mag;
    logic [WANT_W-1:0]           wanted_c;
    logic                        emit_c;
    logic                        div_start;
    logic [DIV_NW-1:0]           div_num;
    logic [DIV_DW-1:0]           div_den;
    logic                        div_done;
    logic [DIV_NW-1:0]           div_q;
    logic signed [DIV_NW:0]      qs;
    logic signed [AS_W-1:0]      acc_sum;
    logic [AS_W-TVAL_W:0]        acc_hi;
    logic signed [TVAL_W-1:0]    acc_sat;
    logic [CHG_W-CHARGE_W:0]     chg_hi;
    logic signed [CHARGE_W-1:0]  chg_sat;
    logic [CHARGE_W-1:0]         charge_abs;
    logic                        sel_c;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // sample capture and scan addressing
    assign cnt_next = (r_cnt < CNT_W'(WAVE_LEN)) ? (r_cnt + 1'b1) : r_cnt;
    assign slen_ext = CNT_W'(r_search_len);
    assign lim      = (slen_ext < cnt_next) ? slen_ext : cnt_next;

    assign scan_state = (r_state == S_SEARCH) || (r_state == S_BSUM) || (r_state == S_CHG);
    assign scan_issue = (r_idx != r_end);
    assign scan_done  = !scan_issue && !r_pend;

    assign wave_we = (r_state == S_IDLE) && start && (r_cnt < CNT_W'(WAVE_LEN));
    always_comb begin
        priority if (r_state == S_IDLE) begin
            wave_addr = r_cnt[WAVE_AW-1:0];
        end else if (r_state == S_TRD) begin
            wave_addr = r_ws + WAVE_AW'(r_j);
        end else begin
            wave_addr = r_idx[WAVE_AW-1:0];
        end
    end
    assign wave_rd = $signed(wave_rdata);

    pcta_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WAVE_LEN)) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (wave_we),
        .i_addr  (wave_addr),
        .i_wdata (i_sample),
        .o_rdata (wave_rdata)
    );

    pcta_ram #(.WIDTH(TVAL_W), .DEPTH(TEMPLATE_LEN)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_addr  (r_j),
        .i_wdata (acc_wdata),
        .o_rdata (acc_rdata)
    );

    // window placement
    assign ws_c = $signed(WS_W'(r_peak)) - $signed(WS_W'(r_lead));
    assign bl_c = ws_c - $signed(WS_W'(r_gap));
    assign past_end = (ws_c + $signed(WS_W'(TEMPLATE_LEN))) > $signed(WS_W'(r_n));

    // baseline-subtracted sample, q.8
    assign s_q8  = {wave_rd, {Q8_SH{1'b0}}};
    assign d_cur = {{(D_W-SQ8_W){s_q8[SQ8_W-1]}}, s_q8}
                 - {{(D_W-BASE_W){r_base[BASE_W-1]}}, r_base};
    assign d_mag = d_cur[D_W-1] ? (-d_cur) : d_cur;
    assign prod  = d_mag * GAIN_W'(TPL_GAIN);

    assign sum_mag  = r_sum[SUM_W-1] ? (-r_sum) : r_sum;
    assign acc_cur  = r_acc_vld[r_j] ? $signed(acc_rdata) : '0;
    assign acc_mag  = acc_cur[TVAL_W-1] ? (-acc_cur) : acc_cur;
    assign wanted_c = (r_wanted == '0) ? WANT_W'(1) : r_wanted;
    assign emit_c   = r_sel && (r_selcnt >= wanted_c);

    // divider operand select, rounding half added to the magnitude
    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_NW'({sum_mag, {Q8_SH{1'b0}}}) + DIV_NW'(r_bl >> 1);
        div_den   = DIV_DW'(r_bl);
        unique case (r_state)
            S_BSUM: begin
                div_start = scan_done;
            end
            S_TLD: begin
                div_start = 1'b1;
                div_num   = {prod, {FRAC_SH{1'b0}}} + DIV_NW'(r_abs >> 1);
                div_den   = r_abs;
            end
            S_ELD: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(acc_mag) + DIV_NW'(wanted_c >> 1);
                div_den   = DIV_DW'(wanted_c);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pcta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign qs = r_dneg ? (-$signed({1'b0, div_q})) : $signed({1'b0, div_q});

    // accumulate with 32-bit saturation
    assign acc_sum = {{(AS_W-TVAL_W){r_accv[TVAL_W-1]}}, r_accv}
                   + {{(AS_W-DIV_NW-1){qs[DIV_NW]}}, qs};
    assign acc_hi  = acc_sum[AS_W-1:TVAL_W-1];
    assign acc_sat = ((&acc_hi) || !(|acc_hi)) ? acc_sum[TVAL_W-1:0]
                   : (acc_sum[AS_W-1] ? {1'b1, {(TVAL_W-1){1'b0}}}
                                      : {1'b0, {(TVAL_W-1){1'b1}}});
    assign acc_we    = (r_state == S_TDIV) && div_done;
    assign acc_wdata = acc_sat;

    assign chg_hi  = r_chg[CHG_W-1:CHARGE_W-1];
    assign chg_sat = ((&chg_hi) || !(|chg_hi)) ? r_chg[CHARGE_W-1:0]
                   : (r_chg[CHG_W-1] ? {1'b1, {(CHARGE_W-1){1'b0}}}
                                     : {1'b0, {(CHARGE_W-1){1'b1}}});

    assign charge_abs = r_charge[CHARGE_W-1] ? (-r_charge) : r_charge;
    assign sel_c = (CHARGE_W'(r_area_lo) < charge_abs) && (charge_abs < CHARGE_W'(r_area_hi));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_search_len <= SLEN_W'(700);
            r_lead       <= OFS_W'(15);
            r_gap        <= OFS_W'(40);
            r_area_lo    <= AREA_W'(25600);
            r_area_hi    <= AREA_W'(38400);
            r_wanted     <= WANT_W'(100);
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_selcnt     <= '0;
            r_acc_vld    <= '0;
            r_o_strobe   <= 1'b0;
        end else begin
            // a summary or a finished template word goes out next cycle
            r_o_strobe <= (r_state == S_SUMM) || ((r_state == S_EDIV) && div_done);

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SEARCH_LEN: r_search_len <= i_cfg_data[SLEN_W-1:0];
                    CFG_LEAD_OFS:   r_lead       <= i_cfg_data[OFS_W-1:0];
                    CFG_BASE_GAP:   r_gap        <= i_cfg_data[OFS_W-1:0];
                    CFG_AREA_LOW:   r_area_lo    <= i_cfg_data[AREA_W-1:0];
                    CFG_AREA_HIGH:  r_area_hi    <= i_cfg_data[AREA_W-1:0];
                    CFG_TPL_WANTED: r_wanted     <= i_cfg_data[WANT_W-1:0];
                    default: ;
                endcase
            end

            // read issue in the cycle before its data
            if (scan_state) begin
                if (scan_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_pend <= scan_issue;
                r_pidx <= r_idx[WAVE_AW-1:0];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_last_sample) begin
                            r_n     <= cnt_next;
                            r_cnt   <= '0;
                            r_idx   <= '0;
                            r_end   <= lim;
                            r_pend  <= 1'b0;
                            r_peak  <= '0;
                            r_state <= S_SEARCH;
                        end else begin
                            r_cnt <= cnt_next;
                        end
                    end
                end
                S_SEARCH: begin
                    if (r_pend && ((r_pidx == '0) || (wave_rd < r_minv))) begin
                        r_minv <= wave_rd;
                        r_peak <= r_pidx;
                    end
                    if (scan_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_ws  <= ws_c[WAVE_AW-1:0];
                    r_bl  <= bl_c[WAVE_AW-1:0];
                    r_idx <= '0;
                    r_end <= CNT_W'(bl_c[WAVE_AW-1:0]);
                    r_sum <= '0;
                    r_charge <= '0;
                    r_sel    <= 1'b0;
                    if (bl_c <= $signed(WS_W'(0))) begin
                        r_status <= STAT_NO_BASE;
                        r_state  <= S_SUMM;
                    end else if (past_end) begin
                        r_status <= STAT_PAST_END;
                        r_state  <= S_SUMM;
                    end else begin
                        r_status <= STAT_OK;
                        r_state  <= S_BSUM;
                    end
                end
                S_BSUM: begin
                    if (r_pend) begin
                        r_sum <= r_sum + {{(SUM_W-SAMPLE_BITS){wave_rd[SAMPLE_BITS-1]}}, wave_rd};
                    end
                    if (scan_done) begin
                        r_dneg  <= r_sum[SUM_W-1];
                        r_state <= S_BDIV;
                    end
                end
                S_BDIV: begin
                    if (div_done) begin
                        r_base  <= qs[BASE_W-1:0];
                        r_idx   <= CNT_W'(r_ws);
                        r_end   <= CNT_W'(r_ws) + CNT_W'(TEMPLATE_LEN);
                        r_chg   <= '0;
                        r_state <= S_CHG;
                    end
                end
                S_CHG: begin
                    if (r_pend) begin
                        r_chg <= r_chg + {{(CHG_W-D_W){d_cur[D_W-1]}}, d_cur};
                    end
                    if (scan_done) begin
                        r_state <= S_CLMP;
                    end
                end
                S_CLMP: begin
                    r_charge <= chg_sat;
                    r_state  <= S_SELCK;
                end
                S_SELCK: begin
                    r_abs <= charge_abs;
                    r_sel <= sel_c;
                    r_j   <= '0;
                    r_state <= sel_c ? S_TRD : S_SUMM;
                end
                S_TRD: begin
                    r_state <= S_TLD;
                end
                S_TLD: begin
                    r_dneg  <= d_cur[D_W-1];
                    r_accv  <= acc_cur;
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (div_done) begin
                        r_acc_vld[r_j] <= 1'b1;
                        if (r_j == TPL_AW'(TEMPLATE_LEN - 1)) begin
                            r_state <= S_TDONE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_TRD;
                        end
                    end
                end
                S_TDONE: begin
                    if (r_selcnt != {WANT_W{1'b1}}) begin
                        r_selcnt <= r_selcnt + 1'b1;
                    end
                    r_state <= S_SUMM;
                end
                S_SUMM: begin
                    r_o_kind     <= KIND_SUMMARY;
                    r_o_charge   <= r_charge;
                    r_o_selected <= r_sel;
                    r_o_peak     <= r_peak;
                    r_o_status   <= r_status;
                    r_o_tidx     <= '0;
                    r_o_tval     <= '0;
                    r_o_last     <= !emit_c;
                    r_j          <= '0;
                    r_state      <= emit_c ? S_ERD : S_IDLE;
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    r_dneg  <= acc_cur[TVAL_W-1];
                    r_state <= S_EDIV;
                end
                S_EDIV: begin
                    if (div_done) begin
                        r_o_kind       <= KIND_TEMPLATE;
                        r_o_charge     <= '0;
                        r_o_selected   <= 1'b0;
                        r_o_peak       <= '0;
                        r_o_status     <= STAT_OK;
                        r_o_tidx       <= r_j;
                        r_o_tval       <= qs[TVAL_W-1:0];
                        r_acc_vld[r_j] <= 1'b0;
                        if (r_j == TPL_AW'(TEMPLATE_LEN - 1)) begin
                            r_o_last <= 1'b1;
                            r_selcnt <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_o_last <= 1'b0;
                            r_j      <= r_j + 1'b1;
                            r_state  <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe         = r_o_strobe;
    assign o_kind           = r_o_kind;
    assign o_charge         = r_o_charge;
    assign o_selected       = r_o_selected;
    assign o_peak_index     = r_o_peak;
    assign o_status         = r_o_status;
    assign o_template_index = r_o_tidx;
    assign o_template_value = r_o_tval;
    assign o_last_result    = r_o_last;

endmodule

// ===== design/pcta_checker.sv =====
// ----------------------------------------------------------------------------
// pcta_checker
// port-level checks of the pulse charge template averager
// ----------------------------------------------------------------------------
`include "pulse_charge_template_averager_macros.svh"

module pcta_checker import pcta_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       busy,
    input logic                       o_strobe,
    input logic                       o_kind,
    input logic signed [CHARGE_W-1:0] o_charge,
    input logic                       o_selected,
    input logic [STATUS_W-1:0]        o_status,
    input logic                       o_last_result
);

    // results only come out of an analysis
    `PCTA_ASSERT_RST(a_strobe_after_busy, i_clk, i_rst_n, o_strobe |-> $past(busy))

    // a rejected window never selects and ends the response
    `PCTA_ASSERT_RST(a_bad_window, i_clk, i_rst_n, (o_strobe && (o_kind == KIND_SUMMARY) && (o_status != STAT_OK)) |-> (!o_selected && (o_charge == '0) && o_last_result))

    // template words only follow a selected pulse
    `PCTA_ASSERT_RST(a_emit_needs_sel, i_clk, i_rst_n, (o_strobe && (o_kind == KIND_SUMMARY) && !o_last_result) |-> o_selected)

    `PCTA_ASSERT_ALL(a_reset_quiet, i_clk, !i_rst_n |=> !o_strobe)

endmodule

bind pulse_charge_template_averager pcta_checker u_pcta_checker (.*);

// ===== tb/sv/tb_pulse_charge_template_averager.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pulse_charge_template_averager
// self-checking bench: waveforms go in sample by sample and an in-bench
// predictor of charge, selection and template averaging checks every result
// ----------------------------------------------------------------------------
module tb_pulse_charge_template_averager;
    import pcta_pkg::*;

    typedef struct {
        logic                       kind;
        logic signed [CHARGE_W-1:0] charge;
        logic                       selected;
        logic [WAVE_AW-1:0]         peak;
        logic [STATUS_W-1:0]        status;
        logic [TPL_AW-1:0]          tidx;
        logic signed [TVAL_W-1:0]   tval;
        logic                       last;
    } t_pulse_result;

    typedef struct {
        int s;
        bit last;
        bit typed;
        int peak;
    } t_sample_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_last_sample;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          o_strobe;
    logic                          o_kind;
    logic signed [CHARGE_W-1:0]    o_charge;
    logic                          o_selected;
    logic [WAVE_AW-1:0]            o_peak_index;
    logic [STATUS_W-1:0]           o_status;
    logic [TPL_AW-1:0]             o_template_index;
    logic signed [TVAL_W-1:0]      o_template_value;
    logic                          o_last_result;

    pulse_charge_template_averager dut (.*);

    // predictor state and configuration
    int            wave_mem [WAVE_LEN];
    int            fill_cnt;
    longint        tpl_acc [TEMPLATE_LEN];
    int            pulse_cnt;
    int            search_len_r, lead_ofs_r, base_gap_r, want_r;
    longint        area_lo_r, area_hi_r;
    t_pulse_result expected_q [$];
    int            errors;

    localparam longint AREA_MAX = 167772160;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic longint div_near(longint num, longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // charge, selection and template update for one accepted sample
    function automatic void predict_pulse(int s, bit last);
        longint n, lim, ws, bl, base, chg, sum, a, d, c;
        int j, pk, mn, want;
        bit sel;
        logic [STATUS_W-1:0] st;
        t_pulse_result r;
        if (fill_cnt < WAVE_LEN) begin
            wave_mem[fill_cnt] = s;
            fill_cnt++;
        end
        if (!last) return;
        n = fill_cnt;
        fill_cnt = 0;
        pk = 0;
        mn = 0;
        lim = search_len_r < n ? search_len_r : n;
        for (j = 0; j < lim; j++) begin
            if (j == 0 || wave_mem[j] < mn) begin
                mn = wave_mem[j];
                pk = j;
            end
        end
        ws = pk - lead_ofs_r;
        bl = ws - base_gap_r;
        base = 0;
        chg = 0;
        a = 0;
        sel = 0;
        st = STAT_OK;
        if (bl <= 0) begin
            st = STAT_NO_BASE;
        end else if (ws + TEMPLATE_LEN > n) begin
            st = STAT_PAST_END;
        end else begin
            sum = 0;
            for (j = 0; j < bl; j++) sum += wave_mem[j];
            base = div_near(sum * 256, bl);
            for (j = 0; j < TEMPLATE_LEN; j++) chg += longint'(wave_mem[ws + j]) * 256 - base;
            chg = sat(chg, -(longint'(1) << 28), (longint'(1) << 28) - 1);
            a = chg < 0 ? -chg : chg;
            sel = a > area_lo_r && a < area_hi_r;
        end
        if (sel) begin
            for (j = 0; j < TEMPLATE_LEN; j++) begin
                d = longint'(wave_mem[ws + j]) * 256 - base;
                c = div_near(d * TPL_GAIN * 65536, a);
                tpl_acc[j] = sat(tpl_acc[j] + c, -64'sd2147483648, 64'sd2147483647);
            end
            if (pulse_cnt < 65535) pulse_cnt++;
        end
        want = want_r == 0 ? 1 : want_r;
        r.kind = KIND_SUMMARY;
        r.charge = chg[CHARGE_W-1:0];
        r.selected = sel;
        r.peak = pk[WAVE_AW-1:0];
        r.status = st;
        r.tidx = '0;
        r.tval = '0;
        r.last = !(sel && pulse_cnt >= want);
        expected_q.push_back(r);
        if (sel && pulse_cnt >= want) begin
            for (j = 0; j < TEMPLATE_LEN; j++) begin
                c = div_near(tpl_acc[j], want);
                r.kind = KIND_TEMPLATE;
                r.charge = '0;
                r.selected = 1'b0;
                r.peak = '0;
                r.status = STAT_OK;
                r.tidx = j[TPL_AW-1:0];
                r.tval = c[TVAL_W-1:0];
                r.last = j == TEMPLATE_LEN - 1;
                expected_q.push_back(r);
                tpl_acc[j] = 0;
            end
            pulse_cnt = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pulse_result e;
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d charge=%0d tidx=%0d", $time,
                         o_kind, o_charge, o_template_index);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_kind !== e.kind || o_charge !== e.charge || o_selected !== e.selected
                    || o_peak_index !== e.peak || o_status !== e.status
                    || o_template_index !== e.tidx || o_template_value !== e.tval
                    || o_last_result !== e.last) begin
                    $display("%0t: mismatch expected kind=%0d charge=%0d sel=%0d peak=%0d",
                             $time, e.kind, e.charge, e.selected, e.peak,
                             " status=%0d tidx=%0d tval=%0d last=%0d",
                             e.status, e.tidx, e.tval, e.last);
                    $display("%0t:          actual   kind=%0d charge=%0d sel=%0d peak=%0d",
                             $time, o_kind, o_charge, o_selected, o_peak_index,
                             " status=%0d tidx=%0d tval=%0d last=%0d",
                             o_status, o_template_index, o_template_value, o_last_result);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(int s, bit last, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_sample = s[SAMPLE_BITS-1:0];
        i_last_sample = last;
        do @(posedge i_clk); while (busy);
        predict_pulse(s, last);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SEARCH_LEN: search_len_r = int'(val & 'h7FF);
            CFG_LEAD_OFS:   lead_ofs_r = int'(val & 'h3FF);
            CFG_BASE_GAP:   base_gap_r = int'(val & 'h3FF);
            CFG_AREA_LOW:   area_lo_r = val & 'hFFFFFFF;
            CFG_AREA_HIGH:  area_hi_r = val & 'hFFFFFFF;
            CFG_TPL_WANTED: want_r = int'(val & 'hFFFF);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (expected_q.size() != 0 || busy) @(posedge i_clk);
        // a trailing sample may still be in flight
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one waveform of length n: baseline, noise and a negative pulse
    task automatic send_wave(int n);
        int j, p, b, amp, w, v, lo, hi;
        bit quiet, noise;
        quiet = $urandom_range(0, 3) == 0;
        noise = $urandom_range(0, 9) == 0;
        lo = lead_ofs_r + base_gap_r + 1;
        hi = n - TEMPLATE_LEN + lead_ofs_r;
        if (hi > n - 1) hi = n - 1;
        if (lo <= hi && $urandom_range(0, 7) != 0) p = $urandom_range(lo, hi);
        else p = $urandom_range(0, n - 1);
        b = $urandom_range(0, 400) - 200;
        amp = $urandom_range(20, 3000);
        w = $urandom_range(1, 12);
        for (j = 0; j < n; j++) begin
            if (noise) begin
                v = $urandom_range(0, 16383) - 8192;
            end else begin
                v = b + $urandom_range(0, 16) - 8;
                if (j >= p && j < p + w) v -= amp * (w - (j - p)) / w;
                if (j == p) v -= 20;
                if (v > 8191) v = 8191;
                if (v < -8192) v = -8192;
            end
            send_sample(v, j == n - 1, quiet ? 0 : $urandom_range(0, 12));
        end
    endtask

    task automatic run_phase(int sl, int lo_ofs, int gp, longint alo, longint ahi, int want,
                             int waves, int wmin, int wmax);
        int k;
        wait_idle();
        write_reg(CFG_SEARCH_LEN, sl);
        write_reg(CFG_LEAD_OFS, lo_ofs);
        write_reg(CFG_BASE_GAP, gp);
        write_reg(CFG_AREA_LOW, alo);
        write_reg(CFG_AREA_HIGH, ahi);
        write_reg(CFG_TPL_WANTED, want);
        for (k = 0; k < waves; k++) begin
            send_wave($urandom_range(wmin, wmax));
        end
    endtask

    // short waveforms under the reset settings: the window never has a baseline
    t_sample_row rows [] = '{
        '{8191, 1, 1, 0}, '{-8192, 1, 1, 0}, '{0, 1, 1, 0}, '{-1, 1, 1, 0},
        '{5, 0, 0, 0}, '{3, 0, 0, 0}, '{-8192, 0, 0, 0}, '{8191, 1, 1, 2},
        '{1, 0, 0, 0}, '{1, 1, 1, 0},
        '{-8192, 0, 0, 0}, '{-8192, 1, 1, 0},
        '{8191, 0, 0, 0}, '{0, 0, 0, 0}, '{-1, 1, 1, 2},
        '{-4096, 0, 0, 0}, '{4095, 0, 0, 0}, '{-4097, 1, 1, 2}
    };

    initial begin
        int i;
        int qn;
        t_pulse_result t;
        start = 1'b0;
        i_sample = '0;
        i_last_sample = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SEARCH_LEN;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        errors = 0;
        fill_cnt = 0;
        pulse_cnt = 0;
        foreach (tpl_acc[i]) tpl_acc[i] = 0;
        search_len_r = 700;
        lead_ofs_r = 15;
        base_gap_r = 40;
        area_lo_r = 25600;
        area_hi_r = 38400;
        want_r = 100;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < rows.size(); i++) begin
            qn = expected_q.size();
            send_sample(rows[i].s, rows[i].last, $urandom_range(0, 3));
            if (rows[i].typed && expected_q.size() == qn + 1) begin
                t.kind = KIND_SUMMARY;
                t.charge = '0;
                t.selected = 1'b0;
                t.peak = rows[i].peak[WAVE_AW-1:0];
                t.status = STAT_NO_BASE;
                t.tidx = '0;
                t.tval = '0;
                t.last = 1'b1;
                expected_q[$] = t;
            end
        end

        run_phase(1024, 0, 1, 0, AREA_MAX, 1, 1, 45, 55);
        run_phase(1024, 3, 5, 1000, 3000000, 0, 1, 50, 60);
        run_phase(1, 0, 0, 0, AREA_MAX, 2, 2, 1, 8);
        run_phase(1024, 1023, 1023, 0, 0, 65535, 1, 1, 8);
        run_phase(1024, 2, 0, 0, AREA_MAX, 3, 1, 44, 50);
        run_phase($urandom_range(40, 1024), $urandom_range(0, 10), $urandom_range(0, 10),
                  $urandom_range(0, 200000), $urandom_range(0, 3000000),
                  $urandom_range(1, 4), 1, 30, 50);

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pcta_pkg.sv
design/pcta_ram.sv
design/pcta_div.sv
design/pulse_charge_template_averager.sv
design/pcta_checker.sv
tb/sv/tb_pulse_charge_template_averager.sv
